// ===== rtl/tst_pkg.sv =====
// tst_pkg: shared constants for the topic subscription table
// no dependencies
package tst_pkg;
  localparam int TOPICS_DEF = 16;
  localparam int SUBS_DEF = 16;
  localparam int KEY_BITS_DEF = 64;
  localparam int SUB_W = 48;
  localparam int STREAM_W = 16;

  localparam logic [1:0] FUNC_SUB_STREAM = 2'd0;
  localparam logic [1:0] FUNC_SUB_DGRAM = 2'd1;
  localparam logic [1:0] FUNC_PUB_STREAM = 2'd2;
  localparam logic [1:0] FUNC_PUB_DGRAM = 2'd3;

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_DUP = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL = 3'd2;
  localparam logic [2:0] ST_LIST_FULL = 3'd3;
  localparam logic [2:0] ST_NO_SUBS = 3'd4;
endpackage

// ===== rtl/tst_ram.sv =====
// tst_ram: generic single-port ram with registered read
// no dependencies
module tst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/topic_subscription_table_top.sv =====
// topic_subscription_table_top: topic lookup and subscriber lists under one sequencer
// depends on tst_pkg and tst_ram
// subscribe finds or adds the topic, then scans its list for a duplicate; publish gives
// one result per list entry, held until out_ready, or one no-subs result for an unknown
// topic or empty list; one item at a time, the key ram and list ram reads set the pace
// reset clears topic count and list counts; rams are left as they are
module topic_subscription_table_top #(
  parameter int TOPICS = tst_pkg::TOPICS_DEF,
  parameter int SUBS_PER_TOPIC = tst_pkg::SUBS_DEF,
  parameter int KEY_BITS = tst_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [63:0] topic_key,
  input  logic [47:0] subscriber,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  topic_index,
  output logic [2:0]  status,
  output logic [47:0] destination,
  output logic        last
);
  localparam int TW = (TOPICS > 1) ? $clog2(TOPICS) : 1;
  localparam int LD = TOPICS * SUBS_PER_TOPIC;
  localparam int LW = (LD > 1) ? $clog2(LD) : 1;
  localparam int CW = $clog2(TOPICS + 1);
  localparam int NW = $clog2(SUBS_PER_TOPIC + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KRD = 3'd1;
  localparam logic [2:0] S_KCMP = 3'd2;
  localparam logic [2:0] S_LRD = 3'd3;
  localparam logic [2:0] S_LCMP = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state;
  logic [1:0] fn;
  logic [KEY_BITS-1:0] key;
  logic [47:0] sub;
  logic [CW-1:0] topic_count;
  logic [NW-1:0] scount [TOPICS];
  logic [NW-1:0] dcount [TOPICS];
  logic [CW-1:0] ti;
  logic [NW-1:0] si;
  logic [TW-1:0] idx;

  logic key_we;
  logic [TW-1:0] key_addr;
  logic [KEY_BITS-1:0] key_rd;
  logic list_we;
  logic [LW-1:0] list_addr;
  logic [47:0] list_rd;
  logic [15:0] srd;
  logic [47:0] wsub;

  logic dg;
  logic [NW-1:0] n;
  assign dg = fn[0];
  assign n = dg ? dcount[idx] : scount[idx];

  assign in_ready = (state == S_IDLE);

  assign key_we = (state == S_KRD) && (ti == topic_count) && !fn[1] && (ti < TOPICS);
  assign key_addr = ti[TW-1:0];
  assign list_addr = LW'(idx) * LW'(SUBS_PER_TOPIC) + LW'(si);
  assign list_we = (state == S_LRD) && !fn[1] && (si == n) && (si < SUBS_PER_TOPIC);
  assign wsub = dg ? sub : {32'd0, sub[15:0]};

  tst_ram #(.WIDTH(KEY_BITS), .DEPTH(TOPICS)) u_keys (
    .clk(clk), .we(key_we), .addr(key_addr), .wdata(key), .rdata(key_rd));
  tst_ram #(.WIDTH(tst_pkg::STREAM_W), .DEPTH(LD)) u_stream (
    .clk(clk), .we(list_we && !dg), .addr(list_addr), .wdata(sub[15:0]), .rdata(srd));
  tst_ram #(.WIDTH(tst_pkg::SUB_W), .DEPTH(LD)) u_dgram (
    .clk(clk), .we(list_we && dg), .addr(list_addr), .wdata(sub), .rdata(list_rd));

  logic [47:0] rd;
  assign rd = dg ? list_rd : {32'd0, srd};

  task automatic put(input logic [2:0] st, input logic [47:0] d, input logic l);
    status <= st;
    destination <= d;
    last <= l;
    out_valid <= 1'b1;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      topic_count <= '0;
      for (int i = 0; i < TOPICS; i++) begin
        scount[i] <= '0;
        dcount[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            fn <= func;
            key <= topic_key[KEY_BITS-1:0];
            sub <= subscriber;
            ti <= '0;
            state <= S_KRD;
          end
        end
        S_KRD: begin
          if (ti == topic_count) begin
            si <= '0;
            if (fn[1]) begin
              topic_index <= 4'd0;
              put(tst_pkg::ST_NO_SUBS, 48'd0, 1'b1);
              state <= S_DONE;
            end else if (ti >= TOPICS) begin
              topic_index <= 4'd0;
              put(tst_pkg::ST_TABLE_FULL, 48'd0, 1'b1);
              state <= S_DONE;
            end else begin
              topic_index <= 4'(ti);
              idx <= ti[TW-1:0];
              topic_count <= topic_count + 1'b1;
              scount[ti[TW-1:0]] <= '0;
              dcount[ti[TW-1:0]] <= '0;
              state <= S_LRD;
            end
          end else begin
            state <= S_KCMP;
          end
        end
        S_KCMP: begin
          if (key_rd == key) begin
            idx <= ti[TW-1:0];
            topic_index <= 4'(ti);
            si <= '0;
            state <= S_LRD;
          end else begin
            ti <= ti + 1'b1;
            state <= S_KRD;
          end
        end
        S_LRD: begin
          if (si == n) begin
            if (fn[1]) begin
              put(tst_pkg::ST_NO_SUBS, 48'd0, 1'b1);
            end else if (si >= SUBS_PER_TOPIC) begin
              put(tst_pkg::ST_LIST_FULL, 48'd0, 1'b1);
            end else begin
              if (dg) dcount[idx] <= n + 1'b1;
              else scount[idx] <= n + 1'b1;
              put(tst_pkg::ST_ADDED, 48'd0, 1'b1);
            end
            state <= S_DONE;
          end else begin
            state <= S_LCMP;
          end
        end
        S_LCMP: begin
          if (fn[1]) begin
            put(tst_pkg::ST_ADDED, rd, (si + 1'b1) == n);
            state <= S_OUT;
          end else if (rd == wsub) begin
            put(tst_pkg::ST_DUP, 48'd0, 1'b1);
            state <= S_DONE;
          end else begin
            si <= si + 1'b1;
            state <= S_LRD;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last) state <= S_IDLE;
            else begin
              si <= si + 1'b1;
              state <= S_LRD;
            end
          end
        end
        S_DONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    topic_count <= TOPICS) else $error("topic count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(destination))
    else $error("result dropped");
endmodule
